### rtl/prfa_pkg.sv
// Package for the pixel rotate/flip address block: field widths, register
// indexes, mode codes and the queue entry type shared by front and back.
// No dependencies.
`timescale 1ns / 1ps

package prfa_pkg;

  localparam int unsigned PIX_W     = 32;
  localparam int unsigned IDX_W     = 24;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  // Room for any clamped size up to the largest supported maximum of 65536.
  localparam int unsigned EXT_W     = 17;

  localparam logic [MODE_W-1:0] MODE_RESET   = MODE_W'(0);
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE   = 3'd0,
    MODE_ROT90  = 3'd1,
    MODE_ROT180 = 3'd2,
    MODE_ROT270 = 3'd3,
    MODE_FLIPV  = 3'd4,
    MODE_FLIPH  = 3'd5,
    MODE_DIAG   = 3'd6
  } mode_e;

  // One classified pixel: the back end forms op_a * op_b + addend.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [EXT_W-1:0] op_a;
    logic [EXT_W-1:0] op_b;
    logic [IDX_W-1:0] addend;
    logic             frame_end;
    logic             mode_error;
  } entry_t;

endpackage

### rtl/prfa_front.sv
// Front end: configuration registers, source column/row counters and the
// per-mode choice of multiply-add operands. Depends on prfa_pkg.
`timescale 1ns / 1ps

module prfa_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prfa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [prfa_pkg::SIZE_W-1:0]       cfg_data_i,
  input  logic                              push_i,
  input  logic [prfa_pkg::PIX_W-1:0]        pixel_i,
  input  logic                              q_full_i,
  output logic                              q_wr_o,
  output prfa_pkg::entry_t                  q_entry_o
);
  import prfa_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam logic [EXT_W-1:0] MAX_W_L = EXT_W'(MAX_WIDTH);
  localparam logic [EXT_W-1:0] MAX_H_L = EXT_W'(MAX_HEIGHT);

  logic [MODE_W-1:0] mode_q;
  logic [SIZE_W-1:0] width_q, height_q;
  logic [XW-1:0]     col_q, col_d;
  logic [YW-1:0]     row_q, row_d;

  logic [EXT_W-1:0]  w_ext, h_ext, wm1, hm1, col_ext, row_ext, x_ext, y_ext;
  logic [EXT_W-1:0]  w_minus_x, h_minus_y;
  logic              row_end, frame_done, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sizes are clamped to one at the bottom and to the maximum at the top.
  always_comb begin
    if (width_q == '0) begin
      w_ext = EXT_W'(1);
    end else if (EXT_W'(width_q) > MAX_W_L) begin
      w_ext = MAX_W_L;
    end else begin
      w_ext = EXT_W'(width_q);
    end
    if (height_q == '0) begin
      h_ext = EXT_W'(1);
    end else if (EXT_W'(height_q) > MAX_H_L) begin
      h_ext = MAX_H_L;
    end else begin
      h_ext = EXT_W'(height_q);
    end
  end

  assign wm1     = w_ext - EXT_W'(1);
  assign hm1     = h_ext - EXT_W'(1);
  assign col_ext = EXT_W'(col_q);
  assign row_ext = EXT_W'(row_q);

  // A counter left beyond a size that shrank mid-frame is taken as the last position.
  assign x_ext = (col_ext < wm1) ? col_ext : wm1;
  assign y_ext = (row_ext < hm1) ? row_ext : hm1;

  assign row_end    = (x_ext == wm1);
  assign frame_done = row_end && (y_ext == hm1);
  assign w_minus_x  = wm1 - x_ext;
  assign h_minus_y  = hm1 - y_ext;

  assign accept = push_i && !q_full_i;
  assign q_wr_o = accept;

  always_comb begin
    if (row_end) begin
      col_d = '0;
      row_d = frame_done ? '0 : YW'(y_ext + EXT_W'(1));
    end else begin
      col_d = XW'(x_ext + EXT_W'(1));
      row_d = YW'(y_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    q_entry_o.pixel      = pixel_i;
    q_entry_o.frame_end  = frame_done;
    q_entry_o.mode_error = 1'b0;
    q_entry_o.op_a       = '0;
    q_entry_o.op_b       = '0;
    q_entry_o.addend     = '0;
    unique case (mode_q)
      MODE_NONE: begin
        q_entry_o.op_a   = y_ext;
        q_entry_o.op_b   = w_ext;
        q_entry_o.addend = IDX_W'(x_ext);
      end
      MODE_ROT90: begin
        q_entry_o.op_a   = w_minus_x;
        q_entry_o.op_b   = h_ext;
        q_entry_o.addend = IDX_W'(y_ext);
      end
      MODE_ROT180: begin
        // W*H-1-(y*W+x) rewritten as (H-1-y)*W + (W-1-x).
        q_entry_o.op_a   = h_minus_y;
        q_entry_o.op_b   = w_ext;
        q_entry_o.addend = IDX_W'(w_minus_x);
      end
      MODE_ROT270: begin
        q_entry_o.op_a   = x_ext;
        q_entry_o.op_b   = h_ext;
        q_entry_o.addend = IDX_W'(h_minus_y);
      end
      MODE_FLIPV: begin
        q_entry_o.op_a   = h_minus_y;
        q_entry_o.op_b   = w_ext;
        q_entry_o.addend = IDX_W'(x_ext);
      end
      MODE_FLIPH: begin
        q_entry_o.op_a   = y_ext;
        q_entry_o.op_b   = w_ext;
        q_entry_o.addend = IDX_W'(w_minus_x);
      end
      MODE_DIAG: begin
        // (W-x)*H-1-y rewritten as (W-1-x)*H + (H-1-y).
        q_entry_o.op_a   = w_minus_x;
        q_entry_o.op_b   = h_ext;
        q_entry_o.addend = IDX_W'(h_minus_y);
      end
      default: begin
        q_entry_o.mode_error = 1'b1;
      end
    endcase
  end

endmodule

### rtl/prfa_queue.sv
// Two-entry queue of classified pixels between the front and back ends.
// Depends on prfa_pkg for the entry type.
`timescale 1ns / 1ps

module prfa_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  prfa_pkg::entry_t wr_entry_i,
  output logic             full_o,
  input  logic             rd_i,
  output prfa_pkg::entry_t rd_entry_o,
  output logic             empty_o
);
  import prfa_pkg::*;

  entry_t      entries_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        do_wr, do_rd;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && !empty_o;
  assign rd_entry_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

### rtl/prfa_back.sv
// Back end: registered multiply, then add into the result register.
// Depends on prfa_pkg for widths and the entry type.
`timescale 1ns / 1ps

module prfa_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  prfa_pkg::entry_t             q_entry_i,
  output logic                         q_rd_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [prfa_pkg::PIX_W-1:0]   pixel_out_o,
  output logic [prfa_pkg::IDX_W-1:0]   dest_index_o,
  output logic                         frame_end_o,
  output logic                         mode_error_o
);
  import prfa_pkg::*;

  logic                 v1_q, v2_q;
  logic                 ready1, ready2, take1;
  logic [2*EXT_W-1:0]   product;
  logic [IDX_W-1:0]     prod_q, addend_q;
  logic [PIX_W-1:0]     pix1_q;
  logic                 fend1_q, err1_q;

  assign ready2  = !v2_q || pop_i;
  assign ready1  = !v1_q || ready2;
  assign take1   = !q_empty_i && ready1;
  assign q_rd_o  = take1;
  assign empty_o = !v2_q;
  assign product = q_entry_i.op_a * q_entry_i.op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= take1;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take1) begin
      prod_q   <= IDX_W'(product);
      addend_q <= q_entry_i.addend;
      pix1_q   <= q_entry_i.pixel;
      fend1_q  <= q_entry_i.frame_end;
      err1_q   <= q_entry_i.mode_error;
    end
    // The index wraps to 24 bits, as the destination field does.
    if (ready2 && v1_q) begin
      dest_index_o <= prod_q + addend_q;
      pixel_out_o  <= pix1_q;
      frame_end_o  <= fend1_q;
      mode_error_o <= err1_q;
    end
  end

endmodule

### rtl/pixel_rotate_flip_address.sv
// Pixel rotate/flip destination addressing. A pushed pixel is visible once
// it has passed the queue, the product register and the result register.
// Throughput: one pixel per cycle while neither side stalls, set by the
// single multiply-add back end. A two-entry queue between the counter front
// end and the back end lets either side stall. Reset is asynchronous, active
// low: counters clear, mode to none, size to 640 by 480, all stages empty.
`timescale 1ns / 1ps

module pixel_rotate_flip_address #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [prfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [prfa_pkg::SIZE_W-1:0]     cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [prfa_pkg::PIX_W-1:0]      pixel_i,
  input  logic                            pop,
  output logic                            empty,
  output logic [prfa_pkg::PIX_W-1:0]      pixel_out_o,
  output logic [prfa_pkg::IDX_W-1:0]      dest_index_o,
  output logic                            frame_end_o,
  output logic                            mode_error_o
);
  import prfa_pkg::*;

  logic   q_wr, q_full, q_rd, q_empty;
  entry_t wr_entry, rd_entry;

  assign full = q_full;

  prfa_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .pixel_i    (pixel_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr),
    .q_entry_o  (wr_entry)
  );

  prfa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_entry_i (wr_entry),
    .full_o     (q_full),
    .rd_i       (q_rd),
    .rd_entry_o (rd_entry),
    .empty_o    (q_empty)
  );

  prfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_entry_i    (rd_entry),
    .q_rd_o       (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .pixel_out_o  (pixel_out_o),
    .dest_index_o (dest_index_o),
    .frame_end_o  (frame_end_o),
    .mode_error_o (mode_error_o)
  );

endmodule

### rtl/prfa_checker.sv
// Port-level checks for the pixel rotate/flip address block, bound to the
// top level. Depends on prfa_pkg for widths.
`timescale 1ns / 1ps

module prfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic [prfa_pkg::PIX_W-1:0]     pixel_out_o,
  input logic [prfa_pkg::IDX_W-1:0]     dest_index_o,
  input logic                           frame_end_o,
  input logic                           mode_error_o
);
  import prfa_pkg::*;

  // While reset is held nothing is waiting on either side.
  a_reset_clear: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("queue not clear during reset");

  // A result that is not taken stays as it is.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(pixel_out_o) && $stable(dest_index_o)
      && $stable(frame_end_o) && $stable(mode_error_o))
    else $error("stalled result changed");

  // An unsupported mode always gives index zero.
  a_error_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && mode_error_o |-> dest_index_o == '0)
    else $error("non-zero index with mode error");

endmodule

bind pixel_rotate_flip_address prfa_checker u_prfa_checker (.*);

### test/testbench.sv
// Self-checking bench for pixel_rotate_flip_address: a directed table, then random
// pixel streams under changing modes, frame sizes and handshake pressure.
// Depends on prfa_pkg and the pixel_rotate_flip_address RTL only.
`timescale 1ns / 1ps

module testbench;
  import prfa_pkg::*;

  localparam int unsigned MAX_SIZE = 4096;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PIXELS_PER_PHASE = 363;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 50;
  localparam int NUM_ROWS = 44;
  // Index with no register behind it; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_INVALID = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [IDX_W-1:0] dest;
    logic             frame_end;
    logic             mode_error;
  } placement_t;

  typedef struct packed {
    logic                 is_write;
    logic [CFG_IDX_W-1:0] addr;
    logic [SIZE_W-1:0]    value;
    logic [PIX_W-1:0]     pixel;
    logic                 typed;
    logic [IDX_W-1:0]     dest;
    logic                 frame_end;
    logic                 mode_error;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b1;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [SIZE_W-1:0]    cfg_data_i = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [PIX_W-1:0]     pixel_i = '0;
  logic                 pop = 1'b0;
  logic                 empty;
  logic [PIX_W-1:0]     pixel_out_o;
  logic [IDX_W-1:0]     dest_index_o;
  logic                 frame_end_o;
  logic                 mode_error_o;

  // Expected values typed into the table travel alongside the pixel.
  logic                 table_check = 1'b0;
  logic [IDX_W-1:0]     table_dest = '0;
  logic                 table_frame_end = 1'b0;
  logic                 table_mode_error = 1'b0;

  // Predictor state: registers and source position.
  logic [MODE_W-1:0]    cur_mode = MODE_RESET;
  logic [SIZE_W-1:0]    cur_width = WIDTH_RESET;
  logic [SIZE_W-1:0]    cur_height = HEIGHT_RESET;
  int unsigned          col_pos = 0;
  int unsigned          row_pos = 0;

  placement_t           pending_placements[$];
  int unsigned          pixels_sent = 0;
  int unsigned          placements_seen = 0;
  int unsigned          frames_seen = 0;
  int unsigned          invalid_seen = 0;
  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;

  row_t directed_rows [NUM_ROWS] = '{
    '{1'b0, CFG_SPARE, 13'd0, 32'h0000_0000, 1'b1, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'hFFFF_FFFF, 1'b1, 24'd1, 1'b0, 1'b0},
    '{1'b1, CFG_WIDTH, 13'd2, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_HEIGHT, 13'd2, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    // The column counter now lies past the narrowed row, so this pixel ends it.
    '{1'b0, CFG_SPARE, 13'd0, 32'hA5A5_A5A5, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h5A5A_5A5A, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h0F0F_0F0F, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_MODE, 13'(MODE_INVALID), 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'hF0F0_F0F0, 1'b1, 24'd0, 1'b0, 1'b1},
    '{1'b1, CFG_SPARE, 13'h1FFF, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_MODE, 13'(MODE_ROT90), 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h1234_5678, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h8765_4321, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'hDEAD_BEEF, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h0000_0001, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_MODE, 13'(MODE_ROT180), 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_WIDTH, 13'd0, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_HEIGHT, 13'd3, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h8000_0000, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h7FFF_FFFF, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h5555_5555, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_MODE, 13'(MODE_ROT270), 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_WIDTH, 13'h1FFF, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_HEIGHT, 13'h1FFF, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'hAAAA_AAAA, 1'b1, 24'd4095, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'hCCCC_CCCC, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_WIDTH, 13'd1, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_HEIGHT, 13'd1, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_MODE, 13'(MODE_FLIPV), 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h3333_3333, 1'b1, 24'd0, 1'b1, 1'b0},
    '{1'b1, CFG_MODE, 13'(MODE_FLIPH), 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_WIDTH, 13'd3, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_HEIGHT, 13'd2, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h0123_4567, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h89AB_CDEF, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'hFEDC_BA98, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_MODE, 13'(MODE_DIAG), 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h7654_3210, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h0F1E_2D3C, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'h4B5A_6978, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_MODE, 13'(MODE_ROT180), 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_WIDTH, 13'd4096, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b1, CFG_HEIGHT, 13'd4096, 32'h0, 1'b0, 24'd0, 1'b0, 1'b0},
    '{1'b0, CFG_SPARE, 13'd0, 32'hC3C3_3C3C, 1'b1, 24'hFF_FFFF, 1'b0, 1'b0}
  };

  pixel_rotate_flip_address #(
    .MAX_WIDTH (MAX_SIZE),
    .MAX_HEIGHT(MAX_SIZE)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .pixel_i     (pixel_i),
    .pop         (pop),
    .empty       (empty),
    .pixel_out_o (pixel_out_o),
    .dest_index_o(dest_index_o),
    .frame_end_o (frame_end_o),
    .mode_error_o(mode_error_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_SIZE) return MAX_SIZE;
    return int'(v);
  endfunction

  // Works out where one source pixel lands and advances the source position.
  function automatic placement_t place_pixel(input logic [PIX_W-1:0] pix);
    placement_t  p;
    int unsigned w, h, x, y, idx;
    logic        row_end;
    w = clamp_size(cur_width);
    h = clamp_size(cur_height);
    x = (col_pos < w - 1) ? col_pos : w - 1;
    y = (row_pos < h - 1) ? row_pos : h - 1;
    row_end = (x == w - 1);
    p.pixel = pix;
    p.frame_end = row_end && (y == h - 1);
    p.mode_error = 1'b0;
    case (cur_mode)
      MODE_NONE:   idx = y * w + x;
      MODE_ROT90:  idx = (w - 1 - x) * h + y;
      MODE_ROT180: idx = w * h - 1 - (y * w + x);
      MODE_ROT270: idx = x * h + (h - 1 - y);
      MODE_FLIPV:  idx = (h - 1 - y) * w + x;
      MODE_FLIPH:  idx = y * w + (w - 1 - x);
      MODE_DIAG:   idx = (w - x) * h - 1 - y;
      default: begin
        idx = 0;
        p.mode_error = 1'b1;
      end
    endcase
    p.dest = IDX_W'(idx);
    if (row_end) begin
      col_pos = 0;
      row_pos = p.frame_end ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
    return p;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR at cycle %0d: %s got 0x%0h, expected 0x%0h",
               cycle_count, field, got, want);
  endtask

  // Observes every transfer at the clock edge: register writes, pixels in, results out.
  always @(posedge clk_i) begin
    placement_t want;
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_placements.size());
      $display("Mismatches found");
      $finish;
    end else if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:   cur_mode = cfg_data_i[MODE_W-1:0];
          CFG_WIDTH:  cur_width = cfg_data_i;
          CFG_HEIGHT: cur_height = cfg_data_i;
          default: ;
        endcase
      end
      if (push && !full) begin
        want = place_pixel(pixel_i);
        if (table_check) begin
          want.dest = table_dest;
          want.frame_end = table_frame_end;
          want.mode_error = table_mode_error;
        end
        pending_placements.push_back(want);
      end
      if (pop && !empty) begin
        placements_seen++;
        frames_seen += frame_end_o;
        invalid_seen += mode_error_o;
        if (pending_placements.size() == 0) begin
          report_mismatch("unexpected result, dest_index", 64'(dest_index_o), 64'd0);
        end else begin
          want = pending_placements.pop_front();
          if (pixel_out_o !== want.pixel)
            report_mismatch("pixel_out", 64'(pixel_out_o), 64'(want.pixel));
          if (dest_index_o !== want.dest)
            report_mismatch("dest_index", 64'(dest_index_o), 64'(want.dest));
          if (frame_end_o !== want.frame_end)
            report_mismatch("frame_end", 64'(frame_end_o), 64'(want.frame_end));
          if (mode_error_o !== want.mode_error)
            report_mismatch("mode_error", 64'(mode_error_o), 64'(want.mode_error));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic wait_idle();
    while (placements_seen < pixels_sent) @(posedge clk_i);
  endtask

  // Registers change only with nothing in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [SIZE_W-1:0] value);
    push <= 1'b0;
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= addr;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic chk,
                            input logic [IDX_W-1:0] dest, input logic fe, input logic err);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    pixel_i <= pix;
    table_check <= chk;
    table_dest <= dest;
    table_frame_end <= fe;
    table_mode_error <= err;
    do @(posedge clk_i); while (full);
    pixels_sent++;
  endtask

  // Mostly small frames so that frame ends come often; now and then the extremes.
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return SIZE_W'($urandom_range(6, 1));
    if (r < 68) return '0;
    if (r < 76) return SIZE_W'(MAX_SIZE);
    if (r < 84) return SIZE_W'($urandom_range(8191, MAX_SIZE + 1));
    return SIZE_W'($urandom_range(MAX_SIZE, 1));
  endfunction

  task automatic reconfigure(input bit write_all);
    if (write_all || $urandom_range(99) < 50)
      write_reg(CFG_MODE, SIZE_W'($urandom_range(7)));
    if (write_all || $urandom_range(99) < 50) write_reg(CFG_WIDTH, pick_size());
    if (write_all || $urandom_range(99) < 50) write_reg(CFG_HEIGHT, pick_size());
    if ($urandom_range(99) < 5) write_reg(CFG_SPARE, SIZE_W'($urandom));
  endtask

  initial begin
    int unsigned phase_sent;
    int unsigned seg_len;
    bit          first_seg;
    // Reset falls once every process is waiting, so the asynchronous clear is seen.
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write)
        write_reg(directed_rows[i].addr, directed_rows[i].value);
      else
        send_pixel(directed_rows[i].pixel, directed_rows[i].typed, directed_rows[i].dest,
                   directed_rows[i].frame_end, directed_rows[i].mode_error);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      phase_sent = 0;
      first_seg = 1'b1;
      while (phase_sent < PIXELS_PER_PHASE) begin
        reconfigure(first_seg);
        first_seg = 1'b0;
        seg_len = $urandom_range(40, 1);
        repeat (seg_len) send_pixel($urandom, 1'b0, '0, 1'b0, 1'b0);
        phase_sent += seg_len;
      end
    end

    push <= 1'b0;
    cfg_we_i <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results from %0d pixels: %0d frame ends, %0d invalid-mode flags.",
             placements_seen, pixels_sent, frames_seen, invalid_seen);
    $display("Modes and frame sizes changed between segments under four handshake loads.");
    if (error_count == 0 && pending_placements.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d results missing", error_count, pending_placements.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
